FILE: rtl/core/ppu_pkg.sv
package ppu_pkg;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned DEPTH_W  = 16;
   localparam int unsigned SX_W     = 13;
   localparam int unsigned SY_W     = 12;
   localparam int unsigned CSR_AW   = 3;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned QTY_W    = 34;

   localparam logic       REG_ALPHA_LIMIT = 1'b0;
   localparam logic [7:0] ALPHA_RESET     = 8'hFF;

   typedef enum logic [1:0] {
      OP_SPAWN  = 2'd0,
      OP_TICK   = 2'd1,
      OP_RENDER = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_REND_RD,
      ST_REND_CHK,
      ST_REND_DIV,
      ST_REND_EMIT,
      ST_REND_FIN
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] pos_x;
      logic [WORD_W-1:0] pos_y;
      logic [WORD_W-1:0] pos_z;
      logic [WORD_W-1:0] vel_x;
      logic [WORD_W-1:0] vel_y;
      logic [WORD_W-1:0] vel_z;
      logic [BYTE_W-1:0] color;
      logic [BYTE_W-1:0] life;
   } entry_type;

   typedef struct packed {
      logic [SX_W-1:0]   screen_x;
      logic [SY_W-1:0]   screen_y;
      logic [BYTE_W-1:0] dot_color;
      logic [BYTE_W-1:0] dot_alpha;
   } dot_type;

endpackage

FILE: rtl/core/ppu_if.sv
interface ppu_req_if;
   logic                                valid;
   logic                                ready;
   logic [ppu_pkg::OP_W-1:0]            op;
   logic signed [ppu_pkg::WORD_W-1:0]   spawn_pos_x;
   logic signed [ppu_pkg::WORD_W-1:0]   spawn_pos_y;
   logic signed [ppu_pkg::WORD_W-1:0]   spawn_pos_z;
   logic signed [ppu_pkg::WORD_W-1:0]   spawn_vel_x;
   logic signed [ppu_pkg::WORD_W-1:0]   spawn_vel_y;
   logic signed [ppu_pkg::WORD_W-1:0]   spawn_vel_z;
   logic [ppu_pkg::BYTE_W-1:0]          spawn_color;
   logic [ppu_pkg::BYTE_W-1:0]          spawn_life;
   logic signed [ppu_pkg::WORD_W-1:0]   camera_x;
   logic signed [ppu_pkg::WORD_W-1:0]   camera_y;
   logic [ppu_pkg::DEPTH_W-1:0]         view_depth;

   modport source (output valid, op, spawn_pos_x, spawn_pos_y, spawn_pos_z, spawn_vel_x,
                   spawn_vel_y, spawn_vel_z, spawn_color, spawn_life, camera_x, camera_y,
                   view_depth, input ready);
   modport sink (input valid, op, spawn_pos_x, spawn_pos_y, spawn_pos_z, spawn_vel_x,
                 spawn_vel_y, spawn_vel_z, spawn_color, spawn_life, camera_x, camera_y,
                 view_depth, output ready);
endinterface

interface ppu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ppu_pkg::SX_W-1:0]     screen_x;
   logic [ppu_pkg::SY_W-1:0]     screen_y;
   logic [ppu_pkg::BYTE_W-1:0]   dot_color;
   logic [ppu_pkg::BYTE_W-1:0]   dot_alpha;
   logic                         dot_valid;
   logic                         last;

   modport source (output valid, screen_x, screen_y, dot_color, dot_alpha, dot_valid, last,
                   input ready);
   modport sink (input valid, screen_x, screen_y, dot_color, dot_alpha, dot_valid, last,
                 output ready);
endinterface

FILE: rtl/core/particle_pool_update_and_project_core.sv
// Spawn: writes the current write slot. Tick: reads each slot in ST_TICK_RD and
// writes back live slots in ST_TICK_WR. Render: runs each live slot through the
// serial 32-step divider and skips each dead slot, then gives the final result.
// One request at a time. Reset clears slot valid bits, write slot, the state
// machine and the output register; alpha_limit resets to 255.
module particle_pool_update_and_project_core #(
   parameter int POOL_SIZE              = 32,
   parameter int SCREEN_WIDTH           = 320,
   parameter int SCREEN_HEIGHT          = 240,
   parameter int SUBPIXEL_BITS          = 4,
   parameter int PROJECTION_BITS        = 8,
   parameter int POSITION_FRACTION_BITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   ppu_req_if.sink                       req_chan,
   ppu_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ppu_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [ppu_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [ppu_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import ppu_pkg::*;

   localparam int AW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int SH    = SUBPIXEL_BITS + PROJECTION_BITS - POSITION_FRACTION_BITS;
   localparam int LSH   = (SH >= 0) ? SH : 0;
   localparam int RSH   = (SH < 0) ? ((-SH > 31) ? 31 : -SH) : 0;
   localparam int CX    = (SCREEN_WIDTH / 2) << SUBPIXEL_BITS;
   localparam int CY    = (SCREEN_HEIGHT / 2) << SUBPIXEL_BITS;
   localparam int LIM_X = (SCREEN_WIDTH - 1) << SUBPIXEL_BITS;
   localparam int LIM_Y = (SCREEN_HEIGHT - 1) << SUBPIXEL_BITS;
   localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

   state_type state_ff, state_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        slot_ff;
   logic [POOL_SIZE-1:0] live_ff;
   logic [BYTE_W-1:0]    alpha_ff;
   logic [WORD_W-1:0]    cam_x_ff, cam_y_ff;
   logic [DEPTH_W-1:0]   depth_ff;
   logic [BYTE_W-1:0]    color_ff, life_ff;
   logic                 hold_valid_ff;
   dot_type              hold_ff, dot_new;
   logic                 out_valid_ff, out_dot_ff, out_last_ff;
   dot_type              out_ff;

   entry_type ram_rd, ram_wd, rd_ent;
   logic              ram_we;
   logic [AW-1:0]     ram_wa;

   logic              accept, out_free, cfg_wr;
   logic              slot_live, done_x, done_y, visible, div_start;
   logic              push_hold, push_fin, take_new;
   logic [WORD_W-1:0] sum_x, sum_y, shl_x, shl_y;
   logic signed [WORD_W-1:0] proj_x, proj_y, qx, qy;
   logic signed [QTY_W-1:0]  sx, sy;
   logic [10:0]       alpha8;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   ppu_ram #(.WIDTH($bits(entry_type)), .DEPTH(POOL_SIZE)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_wa),
      .wdata (ram_wd),
      .raddr (idx_ff),
      .rdata (ram_rd)
   );

   assign slot_live = live_ff[idx_ff];
   always_comb begin
      rd_ent = ram_rd;
      if (!slot_live) begin
         rd_ent.life = '0;
      end
   end

   assign sum_x  = cam_x_ff + rd_ent.pos_x;
   assign sum_y  = cam_y_ff + rd_ent.pos_y;
   assign shl_x  = sum_x << LSH;
   assign shl_y  = sum_y << LSH;
   assign proj_x = $signed(shl_x) >>> RSH;
   assign proj_y = $signed(shl_y) >>> RSH;

   ppu_div u_div_x (
      .clock (clock), .reset (reset), .start (div_start), .dividend (proj_x),
      .divisor (depth_ff), .done (done_x), .quotient (qx)
   );
   ppu_div u_div_y (
      .clock (clock), .reset (reset), .start (div_start), .dividend (proj_y),
      .divisor (depth_ff), .done (done_y), .quotient (qy)
   );

   assign sx = QTY_W'(qx) + QTY_W'(CX);
   assign sy = QTY_W'(qy) + QTY_W'(CY);
   assign visible = !sx[QTY_W-1] && (sx < QTY_W'(LIM_X))
                 && !sy[QTY_W-1] && (sy < QTY_W'(LIM_Y));
   assign alpha8 = {life_ff, 3'b000};

   always_comb begin
      dot_new.screen_x  = sx[SX_W-1:0];
      dot_new.screen_y  = sy[SY_W-1:0];
      dot_new.dot_color = color_ff;
      dot_new.dot_alpha = (alpha8 > {3'b000, alpha_ff}) ? alpha_ff : alpha8[BYTE_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               unique case (op_type'(req_chan.op))
                  OP_TICK:   state_in = ST_TICK_RD;
                  OP_RENDER: state_in = (req_chan.view_depth == '0) ? ST_REND_FIN : ST_REND_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK_RD: state_in = ST_TICK_WR;
         ST_TICK_WR: begin
            state_in = (idx_ff == LAST_SLOT) ? ST_IDLE : ST_TICK_RD;
            idx_in   = idx_ff + AW'(1);
         end
         ST_REND_RD: state_in = ST_REND_CHK;
         ST_REND_CHK: begin
            if (rd_ent.life != '0) begin
               state_in = ST_REND_DIV;
            end else begin
               state_in = (idx_ff == LAST_SLOT) ? ST_REND_FIN : ST_REND_RD;
               idx_in   = idx_ff + AW'(1);
            end
         end
         ST_REND_DIV: if (done_x) state_in = ST_REND_EMIT;
         ST_REND_EMIT: begin
            if (!visible || !hold_valid_ff || out_free) begin
               state_in = (idx_ff == LAST_SLOT) ? ST_REND_FIN : ST_REND_RD;
               idx_in   = idx_ff + AW'(1);
            end
         end
         ST_REND_FIN: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_wa    = idx_ff;
      ram_wd    = rd_ent;
      div_start = 1'b0;
      push_hold = 1'b0;
      push_fin  = 1'b0;
      take_new  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && op_type'(req_chan.op) == OP_SPAWN) begin
               ram_we       = 1'b1;
               ram_wa       = slot_ff;
               ram_wd.pos_x = req_chan.spawn_pos_x;
               ram_wd.pos_y = req_chan.spawn_pos_y;
               ram_wd.pos_z = req_chan.spawn_pos_z;
               ram_wd.vel_x = req_chan.spawn_vel_x;
               ram_wd.vel_y = req_chan.spawn_vel_y;
               ram_wd.vel_z = req_chan.spawn_vel_z;
               ram_wd.color = req_chan.spawn_color;
               ram_wd.life  = req_chan.spawn_life;
            end
         end
         ST_TICK_WR: begin
            if (rd_ent.life != '0) begin
               ram_we       = 1'b1;
               ram_wd.pos_x = rd_ent.pos_x + rd_ent.vel_x;
               ram_wd.pos_y = rd_ent.pos_y + rd_ent.vel_y;
               ram_wd.pos_z = rd_ent.pos_z + rd_ent.vel_z;
               ram_wd.life  = rd_ent.life - 8'd1;
            end
         end
         ST_REND_CHK: div_start = (rd_ent.life != '0);
         ST_REND_EMIT: begin
            if (visible && (!hold_valid_ff || out_free)) begin
               take_new  = 1'b1;
               push_hold = hold_valid_ff;
            end
         end
         ST_REND_FIN: push_fin = out_free;
         default: ;
      endcase
   end

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         slot_ff       <= '0;
         live_ff       <= '0;
         alpha_ff      <= ALPHA_RESET;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (ram_we) begin
            live_ff[ram_wa] <= 1'b1;
         end
         if (accept && op_type'(req_chan.op) == OP_SPAWN) begin
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + AW'(1);
         end
         if (cfg_wr && csr_paddr[2] == REG_ALPHA_LIMIT) begin
            alpha_ff <= csr_pwdata[BYTE_W-1:0];
         end
         if (take_new) begin
            hold_valid_ff <= 1'b1;
         end else if (push_fin) begin
            hold_valid_ff <= 1'b0;
         end
         if (push_hold || push_fin) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         cam_x_ff <= req_chan.camera_x;
         cam_y_ff <= req_chan.camera_y;
         depth_ff <= req_chan.view_depth;
      end
      if (div_start) begin
         color_ff <= rd_ent.color;
         life_ff  <= rd_ent.life;
      end
      if (take_new) begin
         hold_ff <= dot_new;
      end
      if (push_hold) begin
         out_ff      <= hold_ff;
         out_dot_ff  <= 1'b1;
         out_last_ff <= 1'b0;
      end else if (push_fin) begin
         out_ff      <= hold_valid_ff ? hold_ff : '0;
         out_dot_ff  <= hold_valid_ff;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.screen_x  = out_ff.screen_x;
   assign rsp_chan.screen_y  = out_ff.screen_y;
   assign rsp_chan.dot_color = out_ff.dot_color;
   assign rsp_chan.dot_alpha = out_ff.dot_alpha;
   assign rsp_chan.dot_valid = out_dot_ff;
   assign rsp_chan.last      = out_last_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ALPHA_LIMIT) ? CSR_DW'(alpha_ff) : '0;

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.dot_valid |-> rsp_chan.last)
      else $error("end marker without last");

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("held dot left after render pass");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      done_x || done_y |-> state_ff == ST_REND_DIV && done_x == done_y)
      else $error("divider finished out of sequence");
endmodule

FILE: rtl/core/ppu_ram.sv
module ppu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/ppu_div.sv
module ppu_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ppu_pkg::WORD_W-1:0]   dividend,
   input  logic [ppu_pkg::DEPTH_W-1:0]         divisor,
   output logic                                done,
   output logic signed [ppu_pkg::WORD_W-1:0]   quotient
);
   import ppu_pkg::*;

   logic [WORD_W-1:0]  quo_ff, quo_in;
   logic [DEPTH_W-1:0] rem_ff, rem_in;
   logic [DEPTH_W-1:0] div_ff;
   logic               neg_ff;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [DEPTH_W:0]   rem_sh;
   logic [DEPTH_W+1:0] diff;

   assign rem_sh = {rem_ff, quo_ff[WORD_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend[WORD_W-1] ? WORD_W'(-dividend) : dividend;
         rem_in = '0;
         run_in = 1'b1;
         cnt_in = '0;
      end else if (run_ff) begin
         quo_in = {quo_ff[WORD_W-2:0], ~diff[DEPTH_W+1]};
         rem_in = diff[DEPTH_W+1] ? rem_sh[DEPTH_W-1:0] : diff[DEPTH_W-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
         neg_ff <= dividend[WORD_W-1];
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
endmodule
